@@ hw/rtl/rbs_pkg.sv @@
// Shared constants and types for the ray/box slab intersection unit.
package rbs_pkg;

  localparam int WORD_W       = 32;
  localparam int FRAC_BITS    = 16;
  localparam int SMALL_W      = 17;
  localparam int BIG_W        = 31;
  localparam int AXES         = 3;
  // quotient bits kept below the saturation point, plus one output stage
  localparam int DIV_QBITS    = 33;
  localparam int DIV_LAT      = DIV_QBITS + 1;
  localparam int PADDR_W      = 3;

  localparam logic [SMALL_W-1:0] SMALL_RESET = 17'd66;
  localparam logic [BIG_W-1:0]   BIG_RESET   = 31'h7FFF_FFFF;

  // register select is paddr[2]
  localparam logic REG_SMALL = 1'b0;
  localparam logic REG_BIG   = 1'b1;

  typedef struct packed {
    logic [AXES-1:0] nz;   // axis direction near zero, no division used
    logic            bad;  // origin outside a near-zero slab
  } rbs_side_t;

endpackage

@@ hw/rtl/rbs_ray_if.sv @@
// Input channel: one ray and one box per word.
interface rbs_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ray_origin_x;
  logic signed [31:0] ray_origin_y;
  logic signed [31:0] ray_origin_z;
  logic signed [31:0] ray_dir_x;
  logic signed [31:0] ray_dir_y;
  logic signed [31:0] ray_dir_z;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;

  modport source (output valid, ray_origin_x, ray_origin_y, ray_origin_z,
                  ray_dir_x, ray_dir_y, ray_dir_z, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink (input valid, ray_origin_x, ray_origin_y, ray_origin_z,
                ray_dir_x, ray_dir_y, ray_dir_z, box_min_x, box_min_y, box_min_z,
                box_max_x, box_max_y, box_max_z, output ready);
endinterface

@@ hw/rtl/rbs_res_if.sv @@
// Output channel: hit flag with near and far distances.
interface rbs_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] t_near;
  logic signed [31:0] t_far;

  modport source (output valid, hit, t_near, t_far, input ready);
  modport sink (input valid, hit, t_near, t_far, output ready);
endinterface

@@ hw/rtl/rbs_cfg.sv @@
// APB configuration registers.
module rbs_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rbs_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [rbs_pkg::SMALL_W-1:0]       small_threshold,
  output logic [rbs_pkg::BIG_W-1:0]         big_init
);
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_threshold <= rbs_pkg::SMALL_RESET;
      big_init        <= rbs_pkg::BIG_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        rbs_pkg::REG_SMALL: small_threshold <= pwdata[rbs_pkg::SMALL_W-1:0];
        rbs_pkg::REG_BIG:   big_init        <= pwdata[rbs_pkg::BIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rbs_pkg::REG_SMALL: prdata = {{(32-rbs_pkg::SMALL_W){1'b0}}, small_threshold};
      rbs_pkg::REG_BIG:   prdata = {{(32-rbs_pkg::BIG_W){1'b0}}, big_init};
      default:            prdata = '0;
    endcase
  end
endmodule

@@ hw/rtl/rbs_prep.sv @@
// Front stage: slab offsets, magnitudes, signs and near-zero tests.
module rbs_prep (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [31:0]        org [rbs_pkg::AXES],
  input  logic signed [31:0]        dir [rbs_pkg::AXES],
  input  logic signed [31:0]        lo  [rbs_pkg::AXES],
  input  logic signed [31:0]        hi  [rbs_pkg::AXES],
  input  logic [rbs_pkg::SMALL_W-1:0] small_threshold,
  output logic [31:0]               lo_mag [rbs_pkg::AXES],
  output logic [31:0]               hi_mag [rbs_pkg::AXES],
  output logic [31:0]               den_mag [rbs_pkg::AXES],
  output logic [rbs_pkg::AXES-1:0]  lo_neg,
  output logic [rbs_pkg::AXES-1:0]  hi_neg,
  output rbs_pkg::rbs_side_t        side
);
  logic signed [32:0] dlo [rbs_pkg::AXES];
  logic signed [32:0] dhi [rbs_pkg::AXES];
  logic signed [32:0] sdir [rbs_pkg::AXES];
  logic signed [32:0] ssmall;
  logic [rbs_pkg::AXES-1:0] nz;
  logic [rbs_pkg::AXES-1:0] outside;

  assign ssmall = $signed({{(33-rbs_pkg::SMALL_W){1'b0}}, small_threshold});

  always_comb begin
    for (int a = 0; a < rbs_pkg::AXES; a++) begin
      dlo[a]     = $signed({lo[a][31], lo[a]}) - $signed({org[a][31], org[a]});
      dhi[a]     = $signed({hi[a][31], hi[a]}) - $signed({org[a][31], org[a]});
      sdir[a]    = $signed({dir[a][31], dir[a]});
      nz[a]      = (dir[a] == '0) || ((sdir[a] > -ssmall) && (sdir[a] < ssmall));
      outside[a] = (org[a] < lo[a]) || (org[a] > hi[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < rbs_pkg::AXES; a++) begin
        lo_mag[a]  <= dlo[a][32] ? 32'(-dlo[a]) : dlo[a][31:0];
        hi_mag[a]  <= dhi[a][32] ? 32'(-dhi[a]) : dhi[a][31:0];
        den_mag[a] <= sdir[a][32] ? 32'(-sdir[a]) : sdir[a][31:0];
        lo_neg[a]  <= dlo[a][32] ^ dir[a][31];
        hi_neg[a]  <= dhi[a][32] ^ dir[a][31];
      end
      side.nz  <= nz;
      side.bad <= |(nz & outside);
    end
  end
endmodule

@@ hw/rtl/rbs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, saturating Q16.16 result.
module rbs_div (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        num_mag,   // |corner - origin|, scaled by 2^16 inside
  input  logic [31:0]        den_mag,
  input  logic               neg,
  output logic signed [31:0] quot
);
  localparam int QB = rbs_pkg::DIV_QBITS;
  localparam int FB = rbs_pkg::FRAC_BITS;

  logic [31:0]   rem_q [QB];
  logic [31:0]   num_q [QB];
  logic [31:0]   den_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic [QB-1:0] ovf_q;
  logic [QB-1:0] neg_q;
  logic [QB-1:0] mag;

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int B = QB - 1 - k;
    logic [31:0]   rem_in, num_in, den_in;
    logic [QB-1:0] quo_in;
    logic          ovf_in, neg_in, bit_in, ge;
    logic [32:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in = {{(FB+1){1'b0}}, num_mag[31:FB+1]};
      assign num_in = num_mag;
      assign den_in = den_mag;
      assign quo_in = '0;
      // quotient would need more than QB bits
      assign ovf_in = {{(FB+1){1'b0}}, num_mag[31:FB+1]} >= den_mag;
      assign neg_in = neg;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign ovf_in = ovf_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    if (B >= FB) begin : g_bit
      assign bit_in = num_in[B-FB];
    end else begin : g_zero
      assign bit_in = 1'b0;
    end

    assign trial = {rem_in, bit_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? 32'(trial - {1'b0, den_in}) : trial[31:0];
        num_q[k] <= num_in;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QB-2:0], ge};
        ovf_q[k] <= ovf_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  assign mag = quo_q[QB-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_q[QB-1]) begin
        if (ovf_q[QB-1] || (mag > 33'h0_8000_0000)) quot <= 32'sh8000_0000;
        else                                        quot <= 32'(-$signed({1'b0, mag}));
      end else begin
        if (ovf_q[QB-1] || (mag > 33'h0_7FFF_FFFF)) quot <= 32'sh7FFF_FFFF;
        else                                        quot <= mag[31:0];
      end
    end
  end
endmodule

@@ hw/rtl/rbs_reduce.sv @@
// Back stages: order slab distances, narrow the interval, final hit test.
module rbs_reduce (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  rbs_pkg::rbs_side_t            side_in,
  input  logic signed [31:0]            t_lo [rbs_pkg::AXES],
  input  logic signed [31:0]            t_hi [rbs_pkg::AXES],
  input  logic [rbs_pkg::SMALL_W-1:0]   small_threshold,
  input  logic [rbs_pkg::BIG_W-1:0]     big_init,
  output logic                          valid,
  output logic                          hit,
  output logic signed [31:0]            t_near,
  output logic signed [31:0]            t_far
);
  logic                 v1, v2;
  rbs_pkg::rbs_side_t   side1;
  logic                 bad2;
  logic signed [31:0]   tmin [rbs_pkg::AXES];
  logic signed [31:0]   tmax [rbs_pkg::AXES];
  logic signed [31:0]   tn2, tf2, tn_next, tf_next;
  logic                 hit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= valid_in;
      v2    <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < rbs_pkg::AXES; a++) begin
        tmin[a] <= (t_lo[a] > t_hi[a]) ? t_hi[a] : t_lo[a];
        tmax[a] <= (t_lo[a] > t_hi[a]) ? t_lo[a] : t_hi[a];
      end
      side1 <= side_in;
    end
  end

  always_comb begin
    tn_next = -$signed({1'b0, big_init});
    tf_next = $signed({1'b0, big_init});
    for (int a = 0; a < rbs_pkg::AXES; a++) begin
      if (!side1.nz[a]) begin
        if (tmin[a] > tn_next) tn_next = tmin[a];
        if (tmax[a] < tf_next) tf_next = tmax[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tn2  <= tn_next;
      tf2  <= tf_next;
      bad2 <= side1.bad;
    end
  end

  // interval only narrows, so a single check at the end covers every axis
  assign hit_next = !bad2 && !(tn2 > tf2) &&
                    !($signed({tf2[31], tf2}) <
                      $signed({{(33-rbs_pkg::SMALL_W){1'b0}}, small_threshold}));

  always_ff @(posedge clk) begin
    if (en) begin
      hit    <= hit_next;
      t_near <= hit_next ? tn2 : '0;
      t_far  <= hit_next ? tf2 : '0;
    end
  end
endmodule

@@ hw/rtl/ray_box_slab_intersection_unit.sv @@
// Ray / axis-aligned box slab intersection unit, top level.
// An accepted ray word passes the prep stage, the divider bit stages and output stage, then the reduce stages.
// Throughput: one word per cycle while results are taken; six 33-stage bit-per-stage dividers run in parallel.
// The whole pipeline advances together and holds while a result waits unread.
// Reset (rst, synchronous, active high) empties the pipeline and loads register defaults.
module ray_box_slab_intersection_unit (
  input  logic                        clk,
  input  logic                        rst,
  rbs_ray_if.sink                     ray,
  rbs_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  localparam int AX  = rbs_pkg::AXES;
  localparam int LAT = rbs_pkg::DIV_LAT;

  logic                         en;
  logic [rbs_pkg::SMALL_W-1:0]  small_threshold;
  logic [rbs_pkg::BIG_W-1:0]    big_init;
  logic signed [31:0]           org [AX];
  logic signed [31:0]           dir [AX];
  logic signed [31:0]           lo  [AX];
  logic signed [31:0]           hi  [AX];
  logic [31:0]                  lo_mag [AX];
  logic [31:0]                  hi_mag [AX];
  logic [31:0]                  den_mag [AX];
  logic [AX-1:0]                lo_neg, hi_neg;
  rbs_pkg::rbs_side_t           side_p;
  rbs_pkg::rbs_side_t           side_d [LAT];
  logic [LAT-1:0]               vld_d;
  logic                         vld_p;
  logic signed [31:0]           t_lo [AX];
  logic signed [31:0]           t_hi [AX];

  assign en        = !res.valid || res.ready;
  assign ray.ready = en;

  assign org = '{ray.ray_origin_x, ray.ray_origin_y, ray.ray_origin_z};
  assign dir = '{ray.ray_dir_x, ray.ray_dir_y, ray.ray_dir_z};
  assign lo  = '{ray.box_min_x, ray.box_min_y, ray.box_min_z};
  assign hi  = '{ray.box_max_x, ray.box_max_y, ray.box_max_z};

  rbs_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .small_threshold, .big_init
  );

  rbs_prep u_prep (
    .clk, .en, .org, .dir, .lo, .hi, .small_threshold,
    .lo_mag, .hi_mag, .den_mag, .lo_neg, .hi_neg, .side(side_p)
  );

  for (genvar a = 0; a < AX; a++) begin : g_axis
    rbs_div u_div_lo (
      .clk, .en, .num_mag(lo_mag[a]), .den_mag(den_mag[a]), .neg(lo_neg[a]),
      .quot(t_lo[a])
    );
    rbs_div u_div_hi (
      .clk, .en, .num_mag(hi_mag[a]), .den_mag(den_mag[a]), .neg(hi_neg[a]),
      .quot(t_hi[a])
    );
  end

  // valid and side flags ride alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
      vld_d <= '0;
    end else if (en) begin
      vld_p <= ray.valid;
      vld_d <= {vld_d[LAT-2:0], vld_p};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_p;
      for (int i = 1; i < LAT; i++) side_d[i] <= side_d[i-1];
    end
  end

  rbs_reduce u_reduce (
    .clk, .rst, .en,
    .valid_in(vld_d[LAT-1]), .side_in(side_d[LAT-1]),
    .t_lo, .t_hi, .small_threshold, .big_init,
    .valid(res.valid), .hit(res.hit), .t_near(res.t_near), .t_far(res.t_far)
  );
endmodule

@@ hw/rtl/rbs_checker.sv @@
// Port-level checks for the slab intersection unit, bound to the top level.
module rbs_checker (
  input logic               clk,
  input logic               rst,
  input logic               o_valid,
  input logic               o_ready,
  input logic               o_hit,
  input logic signed [31:0] o_t_near,
  input logic signed [31:0] o_t_far
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !o_valid)
    else $error("result valid right after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_hit) |-> (o_t_near == '0 && o_t_far == '0))
    else $error("miss with nonzero distances");

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_hit) |-> (o_t_near <= o_t_far))
    else $error("hit with near beyond far");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_ready) |=> (o_valid && $stable(o_hit) && $stable(o_t_near)
                               && $stable(o_t_far)))
    else $error("stalled result changed");
endmodule

bind ray_box_slab_intersection_unit rbs_checker u_rbs_checker (
  .clk(clk), .rst(rst), .o_valid(res.valid), .o_ready(res.ready), .o_hit(res.hit),
  .o_t_near(res.t_near), .o_t_far(res.t_far)
);
